/* rtl/core/dwv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwv_pkg
// Shared types, command codes, register indexes and the mix attenuation
// table for the dry/wet volume ramp controller.
// ----------------------------------------------------------------------------
package dwv_pkg;

  // Level and fixed-point widths.
  localparam int LVL_W  = 8;
  localparam int FRAC_W = 16;
  localparam int ACC_W  = LVL_W + FRAC_W;
  localparam int INC_W  = ACC_W + 1;
  localparam int NUM_CH = 4;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Channel positions: wet left, wet right, dry left, dry right.
  localparam int CH_WET_L = 0;
  localparam int CH_WET_R = 1;
  localparam int CH_DRY_L = 2;
  localparam int CH_DRY_R = 3;

  // Reset values.
  localparam logic [1:0] MODE_RST    = 2'd0;
  localparam logic [7:0] DIVIDER_RST = 8'd200;
  localparam logic [6:0] MIX_RST     = 7'd50;

  // A mix at or above this value mutes the dry path.
  localparam logic [6:0] MIX_FULL = 7'd100;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_WET   = 3'd1,
    CMD_DRY   = 3'd2,
    CMD_ONOFF = 3'd3,
    CMD_MIX   = 3'd4
  } cmd_t;

  // Routing modes.
  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_EXCL   = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 2'd1;

  // Half-dB attenuation for mix 0..99.
  localparam logic [6:0] MIX_ATTEN [100] = '{
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd1,  7'd1,  7'd1,
    7'd1,  7'd1,  7'd1,  7'd1,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,
    7'd3,  7'd3,  7'd3,  7'd3,  7'd4,  7'd4,  7'd4,  7'd4,  7'd4,  7'd5,
    7'd5,  7'd5,  7'd6,  7'd6,  7'd6,  7'd6,  7'd7,  7'd7,  7'd8,  7'd8,
    7'd8,  7'd9,  7'd9,  7'd9,  7'd10, 7'd10, 7'd11, 7'd11, 7'd12, 7'd12,
    7'd13, 7'd13, 7'd14, 7'd14, 7'd15, 7'd16, 7'd16, 7'd17, 7'd18, 7'd19,
    7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd27, 7'd28, 7'd30,
    7'd31, 7'd33, 7'd35, 7'd37, 7'd40, 7'd43, 7'd47, 7'd52, 7'd59, 7'd71
  };

  // One input command.
  typedef struct packed {
    logic [2:0]       cmd;
    logic [LVL_W-1:0] left_level;
    logic [LVL_W-1:0] right_level;
    logic             effect_on;
    logic [6:0]       mix_percent;
  } item_t;

  // Ramp requests from the command decoder to the four lanes.
  typedef struct packed {
    logic                          advance;
    logic [NUM_CH-1:0]             start;
    logic [NUM_CH-1:0][LVL_W-1:0]  target;
  } ramp_cmd_t;

  // Status of one ramp lane.
  typedef struct packed {
    logic             active;
    logic             pend;
    logic [LVL_W-1:0] next_int;
  } lane_stat_t;

  // Dry level derived from a wet level and the mix, clamped at zero.
  function automatic logic [LVL_W-1:0] mix_attenuate(input logic [LVL_W-1:0] level,
                                                     input logic [6:0] m);
    logic [LVL_W-1:0] a;
    a = '0;
    if (m >= MIX_FULL) begin
      return '0;
    end
    a = {1'b0, MIX_ATTEN[m]};
    return (level > a) ? level - a : '0;
  endfunction

endpackage

/* rtl/core/dwv_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwv_if
// Valid/ready channel interfaces for commands, output words and
// configuration writes.
// ----------------------------------------------------------------------------

// Command channel.
interface dwv_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] left_level;
  logic [7:0] right_level;
  logic       effect_on;
  logic [6:0] mix_percent;

  modport source (output valid, output cmd, output left_level, output right_level,
                  output effect_on, output mix_percent, input ready);
  modport sink   (input valid, input cmd, input left_level, input right_level,
                  input effect_on, input mix_percent, output ready);
endinterface

// Output word channel.
interface dwv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] spi_word;

  modport source (output valid, output spi_word, input ready);
  modport sink   (input valid, input spi_word, output ready);
endinterface

// Configuration write channel.
interface dwv_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/dwv_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwv_ctrl
// Command decoder: keeps stored levels, effect state, mix and the tick
// counter, and turns each command into ramp start and advance requests.
// ----------------------------------------------------------------------------
module dwv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              exec,
  input  dwv_pkg::item_t    item,
  input  logic [1:0]        mode,
  input  logic [7:0]        divider,
  output dwv_pkg::ramp_cmd_t ramp_cmd,
  output logic              tick_fire
);
  import dwv_pkg::*;

  logic [NUM_CH-1:0][LVL_W-1:0] stored_r, stored_nxt;
  logic                         eff_r, eff_nxt;
  logic [6:0]                   mix_r, mix_nxt;
  logic [7:0]                   tick_r, tick_nxt;
  logic [LVL_W-1:0]             src_l, src_r, att_l, att_r;
  logic [6:0]                   mix_use;
  logic                         wet_go, dry_go, adv;
  logic [LVL_W-1:0]             wet_l, wet_rt, dry_l, dry_rt;

  // The ramps advance on the tick that reaches the divider.
  assign tick_fire = (tick_r >= divider);

  // Dry pair derived from the mix, from the new or the stored wet levels.
  always_comb begin
    src_l   = (item.cmd == CMD_WET) ? item.left_level  : stored_r[CH_WET_L];
    src_r   = (item.cmd == CMD_WET) ? item.right_level : stored_r[CH_WET_R];
    mix_use = (item.cmd == CMD_MIX) ? item.mix_percent : mix_r;
    att_l   = mix_attenuate(src_l, mix_use);
    att_r   = mix_attenuate(src_r, mix_use);
  end

  // Command decode.
  always_comb begin
    stored_nxt = stored_r;
    eff_nxt    = eff_r;
    mix_nxt    = mix_r;
    tick_nxt   = tick_r;
    adv        = 1'b0;
    wet_go     = 1'b0;
    dry_go     = 1'b0;
    wet_l      = item.left_level;
    wet_rt     = item.right_level;
    dry_l      = item.left_level;
    dry_rt     = item.right_level;
    unique case (item.cmd)
      CMD_TICK: begin
        if (tick_fire) begin
          tick_nxt = '0;
          adv      = 1'b1;
        end else begin
          tick_nxt = tick_r + 8'd1;
        end
      end
      CMD_WET: begin
        stored_nxt[CH_WET_L] = item.left_level;
        stored_nxt[CH_WET_R] = item.right_level;
        if (mode == MODE_MANUAL) begin
          wet_go = 1'b1;
        end else if (mode == MODE_EXCL) begin
          wet_go = eff_r;
          dry_go = !eff_r;
        end else if (mode == MODE_AUTO) begin
          dry_go = 1'b1;
          if (eff_r) begin
            stored_nxt[CH_DRY_L] = att_l;
            stored_nxt[CH_DRY_R] = att_r;
            dry_l  = att_l;
            dry_rt = att_r;
            wet_go = 1'b1;
          end
        end
      end
      CMD_DRY: begin
        stored_nxt[CH_DRY_L] = item.left_level;
        stored_nxt[CH_DRY_R] = item.right_level;
        dry_go = 1'b1;
      end
      CMD_ONOFF: begin
        eff_nxt = item.effect_on;
        if (mode == MODE_AUTO || mode == MODE_EXCL) begin
          wet_go = 1'b1;
          dry_go = 1'b1;
          if (item.effect_on) begin
            wet_l  = stored_r[CH_WET_L];
            wet_rt = stored_r[CH_WET_R];
            if (mode == MODE_AUTO) begin
              stored_nxt[CH_DRY_L] = att_l;
              stored_nxt[CH_DRY_R] = att_r;
              dry_l  = att_l;
              dry_rt = att_r;
            end else begin
              dry_l  = '0;
              dry_rt = '0;
            end
          end else begin
            wet_l  = '0;
            wet_rt = '0;
            dry_l  = stored_r[CH_WET_L];
            dry_rt = stored_r[CH_WET_R];
          end
        end
      end
      CMD_MIX: begin
        mix_nxt              = item.mix_percent;
        stored_nxt[CH_DRY_L] = att_l;
        stored_nxt[CH_DRY_R] = att_r;
        dry_l  = att_l;
        dry_rt = att_r;
        dry_go = eff_r;
      end
      default: begin
      end
    endcase
  end

  // Requests to the lanes, only for the command being executed.
  always_comb begin
    ramp_cmd                  = '0;
    ramp_cmd.advance          = exec && adv;
    ramp_cmd.start[CH_WET_L]  = exec && wet_go;
    ramp_cmd.start[CH_WET_R]  = exec && wet_go;
    ramp_cmd.start[CH_DRY_L]  = exec && dry_go;
    ramp_cmd.start[CH_DRY_R]  = exec && dry_go;
    ramp_cmd.target[CH_WET_L] = wet_l;
    ramp_cmd.target[CH_WET_R] = wet_rt;
    ramp_cmd.target[CH_DRY_L] = dry_l;
    ramp_cmd.target[CH_DRY_R] = dry_rt;
  end

  // Command state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r <= '0;
      eff_r    <= 1'b0;
      mix_r    <= MIX_RST;
      tick_r   <= '0;
    end else if (exec) begin
      stored_r <= stored_nxt;
      eff_r    <= eff_nxt;
      mix_r    <= mix_nxt;
      tick_r   <= tick_nxt;
    end
  end

endmodule

/* rtl/core/dwv_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwv_lane
// One volume ramp: 8.16 level, target, step count, and the increment
// computed from the start difference by a reciprocal multiply.
// ----------------------------------------------------------------------------
module dwv_lane #(
  parameter int STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    advance,
  input  logic [dwv_pkg::LVL_W-1:0] target,
  output dwv_pkg::lane_stat_t     stat
);
  import dwv_pkg::*;

  // Exact truncating division by STEPS for magnitudes below 2^ACC_W.
  localparam int     SW      = $clog2(STEPS + 1);
  localparam int     LG      = $clog2(STEPS);
  localparam int     SHIFT   = ACC_W + LG;
  localparam int     PROD_W  = SHIFT + ACC_W;
  localparam longint RECIP   = ((longint'(1) << SHIFT) + longint'(STEPS) - 1) / STEPS;
  localparam logic [INC_W-1:0] RECIP_W = INC_W'(RECIP);
  localparam logic [SW-1:0]    STEPS_W = SW'(STEPS);

  logic [ACC_W-1:0] level_r, level_nxt, lvl_adv;
  logic [LVL_W-1:0] target_r, target_nxt;
  logic [SW-1:0]    steps_r, steps_nxt;
  logic [INC_W-1:0] diff_r, diff_nxt;
  logic [INC_W-1:0] inc_r, inc_nxt, inc_calc, mag;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0] quot;
  logic             pend_r, pend_nxt;
  logic             active;

  // Increment from the registered start difference.
  always_comb begin
    mag      = diff_r[INC_W-1] ? (~diff_r + INC_W'(1)) : diff_r;
    prod     = PROD_W'(mag[ACC_W-1:0]) * PROD_W'(RECIP_W);
    quot     = prod[SHIFT +: ACC_W];
    inc_calc = diff_r[INC_W-1] ? (INC_W'(0) - {1'b0, quot}) : {1'b0, quot};
  end

  // One ramp step; the last step lands exactly on the target.
  assign active  = (steps_r != '0);
  assign lvl_adv = (steps_r == SW'(1)) ? {target_r, FRAC_W'(0)}
                                       : level_r + inc_r[ACC_W-1:0];

  always_comb begin
    stat.active   = active;
    stat.pend     = pend_r;
    stat.next_int = active ? lvl_adv[ACC_W-1 -: LVL_W] : level_r[ACC_W-1 -: LVL_W];
  end

  // Next state.
  always_comb begin
    level_nxt  = level_r;
    target_nxt = target_r;
    steps_nxt  = steps_r;
    diff_nxt   = diff_r;
    pend_nxt   = 1'b0;
    inc_nxt    = pend_r ? inc_calc : inc_r;
    if (start) begin
      target_nxt = target;
      steps_nxt  = STEPS_W;
      diff_nxt   = {1'b0, target, FRAC_W'(0)} - {1'b0, level_r};
      pend_nxt   = 1'b1;
    end else if (advance && active) begin
      level_nxt = lvl_adv;
      steps_nxt = steps_r - SW'(1);
    end
  end

  // Ramp state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      target_r <= '0;
      steps_r  <= '0;
      inc_r    <= '0;
      pend_r   <= 1'b0;
    end else begin
      level_r  <= level_nxt;
      target_r <= target_nxt;
      steps_r  <= steps_nxt;
      inc_r    <= inc_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // Start difference, consumed by the multiplier in the cycle after a start.
  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
  end

endmodule

/* rtl/core/dry_wet_volume_ramp_controller_top.sv */
`timescale 1ns / 1ps
// Path: a firing refresh tick waits in the input register; its word is loaded into the output register.
// Throughput: one command per cycle unless stalled; a refresh tick that fires
//   waits after a ramp start while the lane multiplier forms the new increment,
//   and waits while the output register holds an untaken word.
// Reset: synchronous, active low; clears ramps, levels and counters, mode 0,
//   divider 200, mix 50.
// ----------------------------------------------------------------------------
// dry_wet_volume_ramp_controller_top
// Four-channel dry/wet volume ramp controller with input and output
// registers, command decoder and four ramp lanes.
// ----------------------------------------------------------------------------
module dry_wet_volume_ramp_controller_top #(
  parameter int STEPS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  dwv_in_if.sink     in_ch,
  dwv_out_if.source  out_ch,
  dwv_cfg_if.sink    cfg_ch
);
  import dwv_pkg::*;

  logic [1:0]           mode_r;
  logic [7:0]           divider_r;
  logic                 a_valid_r;
  item_t                a_item_r;
  logic                 out_valid_r;
  logic [31:0]          word_r, word_nxt;
  ramp_cmd_t            ramp_cmd;
  lane_stat_t [NUM_CH-1:0] stat;
  logic                 tick_fire, pend_any, active_any, stall, exec, load;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RST;
      divider_r <= DIVIDER_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MODE:    mode_r    <= cfg_ch.data[1:0];
        REG_DIVIDER: divider_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // Hold a refresh tick while an increment is in flight or the output is full.
  always_comb begin
    pend_any   = 1'b0;
    active_any = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      pend_any   = pend_any | stat[ch].pend;
      active_any = active_any | stat[ch].active;
    end
  end

  assign stall = (a_item_r.cmd == CMD_TICK) && tick_fire &&
                 (pend_any || (out_valid_r && !out_ch.ready));
  assign exec  = a_valid_r && !stall;
  assign in_ch.ready = !a_valid_r || exec;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_item_r.cmd         <= in_ch.cmd;
      a_item_r.left_level  <= in_ch.left_level;
      a_item_r.right_level <= in_ch.right_level;
      a_item_r.effect_on   <= in_ch.effect_on;
      a_item_r.mix_percent <= in_ch.mix_percent;
    end
  end

  // Command decoder.
  dwv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .exec     (exec),
    .item     (a_item_r),
    .mode     (mode_r),
    .divider  (divider_r),
    .ramp_cmd (ramp_cmd),
    .tick_fire(tick_fire)
  );

  // Ramp lanes.
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    dwv_lane #(.STEPS(STEPS)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (ramp_cmd.start[ch]),
      .advance(ramp_cmd.advance),
      .target (ramp_cmd.target[ch]),
      .stat   (stat[ch])
    );
  end

  // Output word, channel 0 (wet left) in the low byte.
  always_comb begin
    word_nxt = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      word_nxt[LVL_W*ch +: LVL_W] = stat[ch].next_int;
    end
  end

  assign load = ramp_cmd.advance && active_any;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.spi_word = word_r;

endmodule

/* rtl/core/dwv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwv_checker
// Port-level checks of the output channel, reset state and configuration
// port, bound to the top level.
// ----------------------------------------------------------------------------
module dwv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic        cfg_ready
);

  // A waiting output word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before transfer");

  // A waiting output word keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("output word changed before transfer");

  // Leaving reset, no word is offered and a command can be taken.
  a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid && in_ready)
    else $error("output or input register not empty after reset");

  // Configuration writes never stall.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind dry_wet_volume_ramp_controller_top dwv_checker u_dwv_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_word (out_ch.spi_word),
  .cfg_ready(cfg_ch.ready)
);

/* tb/dwv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwv_scoreboard
// Watches the command, word and configuration channels of the dry/wet volume
// ramp controller, keeps its own copy of the routing and ramp state, predicts
// the level word of every refresh tick and compares each word transfer with
// the oldest prediction.
// ----------------------------------------------------------------------------
module dwv_scoreboard #(
  parameter int STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  dwv_in_if    in_mon,
  dwv_out_if   out_mon,
  dwv_cfg_if   cfg_mon,
  output int   fail_count,
  output int   words_due
);
  import dwv_pkg::*;

  // Shadow configuration.
  logic [1:0] mode_q;
  logic [7:0] divider_q;

  // Shadow routing and ramp state.
  logic [LVL_W-1:0]        lvl_store [NUM_CH];
  logic                    fx_on;
  logic [6:0]              mix_reg;
  logic [7:0]              tick_cnt;
  logic [ACC_W-1:0]        acc       [NUM_CH];
  logic signed [INC_W-1:0] step_inc  [NUM_CH];
  logic [LVL_W-1:0]        tgt       [NUM_CH];
  logic [6:0]              steps_rem [NUM_CH];

  // Level words predicted but not yet seen on the output channel.
  logic [31:0] pending_words [$];

  // Start a ramp from the current level toward a new target.
  function automatic void begin_ramp(input int ch, input logic [LVL_W-1:0] target);
    logic signed [31:0] span;
    span = $signed({8'd0, target, 16'd0}) - $signed({8'd0, acc[ch]});
    step_inc[ch]  = INC_W'(span / STEPS);
    tgt[ch]       = target;
    steps_rem[ch] = 7'(STEPS);
  endfunction

  // Start ramps on a channel pair (wet or dry).
  function automatic void route_pair(input int base, input logic [LVL_W-1:0] l,
                                     input logic [LVL_W-1:0] r);
    begin_ramp(base, l);
    begin_ramp(base + 1, r);
  endfunction

  // Dry level from a wet level and the effective mix, floored at zero.
  function automatic logic [LVL_W-1:0] faded_level(input logic [LVL_W-1:0] level,
                                                   input logic [6:0] m);
    logic [LVL_W:0] diff;
    if (m >= MIX_FULL) return '0;
    diff = {1'b0, level} - {2'b00, MIX_ATTEN[m]};
    return diff[LVL_W] ? '0 : diff[LVL_W-1:0];
  endfunction

  // Store a mix, rederive the dry pair from the wet levels and, with the effect on, ramp to it.
  function automatic void remix(input logic [6:0] raw);
    logic [6:0] m;
    mix_reg = raw;
    m = (raw > MIX_FULL) ? MIX_FULL : raw;
    lvl_store[CH_DRY_L] = faded_level(lvl_store[CH_WET_L], m);
    lvl_store[CH_DRY_R] = faded_level(lvl_store[CH_WET_R], m);
    if (fx_on) route_pair(CH_DRY_L, lvl_store[CH_DRY_L], lvl_store[CH_DRY_R]);
  endfunction

  // Advance every active ramp by one step; the last step lands on the target.
  function automatic bit step_ramps();
    bit moved;
    logic [31:0] sum;
    moved = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (steps_rem[ch] != 7'd0) begin
        if (steps_rem[ch] == 7'd1) begin
          acc[ch] = {tgt[ch], 16'd0};
        end else begin
          sum = {8'd0, acc[ch]} + {{(32-INC_W){step_inc[ch][INC_W-1]}}, step_inc[ch]};
          acc[ch] = sum[ACC_W-1:0];
        end
        steps_rem[ch] = steps_rem[ch] - 7'd1;
        moved = 1'b1;
      end
    end
    return moved;
  endfunction

  // Apply one command; returns 1 when a level word is produced.
  function automatic bit predict_word(input item_t it, output logic [31:0] word);
    word = '0;
    case (it.cmd)
      CMD_TICK: begin
        if (tick_cnt >= divider_q) begin
          tick_cnt = '0;
          if (step_ramps()) begin
            word = {acc[3][ACC_W-1:FRAC_W], acc[2][ACC_W-1:FRAC_W],
                    acc[1][ACC_W-1:FRAC_W], acc[0][ACC_W-1:FRAC_W]};
            return 1'b1;
          end
        end else begin
          tick_cnt = tick_cnt + 8'd1;
        end
      end
      CMD_WET: begin
        lvl_store[CH_WET_L] = it.left_level;
        lvl_store[CH_WET_R] = it.right_level;
        if (mode_q == MODE_MANUAL) begin
          route_pair(CH_WET_L, it.left_level, it.right_level);
        end else if (mode_q == MODE_EXCL) begin
          route_pair(fx_on ? CH_WET_L : CH_DRY_L, it.left_level, it.right_level);
        end else if (mode_q == MODE_AUTO) begin
          if (fx_on) begin
            remix(mix_reg);
            route_pair(CH_WET_L, it.left_level, it.right_level);
          end else begin
            route_pair(CH_DRY_L, it.left_level, it.right_level);
          end
        end
      end
      CMD_DRY: begin
        lvl_store[CH_DRY_L] = it.left_level;
        lvl_store[CH_DRY_R] = it.right_level;
        route_pair(CH_DRY_L, it.left_level, it.right_level);
      end
      CMD_ONOFF: begin
        fx_on = it.effect_on;
        if (mode_q == MODE_AUTO || mode_q == MODE_EXCL) begin
          if (it.effect_on) begin
            if (mode_q == MODE_AUTO) remix(mix_reg);
            route_pair(CH_WET_L, lvl_store[CH_WET_L], lvl_store[CH_WET_R]);
            if (mode_q == MODE_EXCL) route_pair(CH_DRY_L, '0, '0);
          end else begin
            route_pair(CH_WET_L, '0, '0);
            route_pair(CH_DRY_L, lvl_store[CH_WET_L], lvl_store[CH_WET_R]);
          end
        end
      end
      CMD_MIX: remix(it.mix_percent);
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Track every transfer on the three channels.
  always @(posedge clk) begin : monitor
    item_t       it;
    logic [31:0] want;
    bit          has_word;
    if (!rst_n) begin
      mode_q    = MODE_RST;
      divider_q = DIVIDER_RST;
      fx_on     = 1'b0;
      mix_reg   = MIX_RST;
      tick_cnt  = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        lvl_store[ch] = '0;
        acc[ch]       = '0;
        step_inc[ch]  = '0;
        tgt[ch]       = '0;
        steps_rem[ch] = '0;
      end
      pending_words.delete();
    end else begin
      // Output words are checked before this edge's command adds a new one.
      if (out_mon.valid && out_mon.ready) begin
        if (pending_words.size() == 0) begin
          if (fail_count < 50)
            $display("%0t: unexpected spi_word, expected none, got %08h",
                     $time, out_mon.spi_word);
          fail_count = fail_count + 1;
        end else begin
          want = pending_words.pop_front();
          if (want !== out_mon.spi_word) begin
            if (fail_count < 50)
              $display("%0t: spi_word mismatch, expected %08h, got %08h",
                       $time, want, out_mon.spi_word);
            fail_count = fail_count + 1;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_MODE) mode_q = cfg_mon.data[1:0];
        else if (cfg_mon.index == REG_DIVIDER) divider_q = cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready) begin
        it.cmd         = in_mon.cmd;
        it.left_level  = in_mon.left_level;
        it.right_level = in_mon.right_level;
        it.effect_on   = in_mon.effect_on;
        it.mix_percent = in_mon.mix_percent;
        has_word = predict_word(it, want);
        if (has_word) pending_words.push_back(want);
      end
    end
    words_due = pending_words.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the dry/wet volume ramp controller. A directed
// burst at the reset settings is followed by random command streams under
// several mode and divider settings, with random idling on both sides, a
// long output stall and a full drain. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb;
  import dwv_pkg::*;

  localparam int         RAMP_STEPS    = 16;
  localparam int         CLK_HALF      = 4;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         LIMIT         = 300000;
  localparam logic [1:0] MODE_RSVD     = 2'd3;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   words_due;
  int   cycle_cnt;

  // Receiver idling controls, set by the stimulus process.
  int   rx_idle_pct;
  bit   hold_req;

  dwv_in_if  in_ch ();
  dwv_out_if out_ch ();
  dwv_cfg_if cfg_ch ();

  dry_wet_volume_ramp_controller_top #(.STEPS(RAMP_STEPS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  dwv_scoreboard #(.STEPS(RAMP_STEPS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Output ready: random stall bursts, plus one long hold on request.
  initial begin : word_sink
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < rx_idle_pct) begin
        gap_left = $urandom_range(11, 1) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One command transfer, optionally after an idle burst.
  task automatic send_cmd(input item_t it, input int idle_pct);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(11, 1) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= it.cmd;
    in_ch.left_level  <= it.left_level;
    in_ch.right_level <= it.right_level;
    in_ch.effect_on   <= it.effect_on;
    in_ch.mix_percent <= it.mix_percent;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted word has been taken.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write transfer.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic item_t make_cmd(input logic [2:0] cmd, input logic [7:0] l,
                                     input logic [7:0] r, input logic on,
                                     input logic [6:0] mix);
    item_t it;
    it.cmd         = cmd;
    it.left_level  = l;
    it.right_level = r;
    it.effect_on   = on;
    it.mix_percent = mix;
    return it;
  endfunction

  // Level with extra weight on the ends of the range.
  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Random command, ticks at the given share.
  function automatic item_t random_cmd(input int tick_pct);
    logic [2:0] cmd;
    logic [6:0] mix;
    int         r;
    r = $urandom_range(99);
    if (r < tick_pct) cmd = CMD_TICK;
    else if (r < tick_pct + 2) cmd = CMD_UNUSED_LO + 3'($urandom_range(2));
    else cmd = 3'($urandom_range(CMD_MIX, CMD_WET));
    mix = 7'(($urandom_range(99) < 30) ? $urandom_range(127, 95) : $urandom_range(127));
    return make_cmd(cmd, pick_level(), pick_level(), 1'($urandom_range(1)), mix);
  endfunction

  // One random phase under a given mode and divider.
  task automatic run_phase(input logic [1:0] mode, input logic [7:0] div, input int count,
                           input int tick_pct, input int idle_pct, input bit mid_pause,
                           input bit long_hold);
    settle();
    write_reg(REG_MODE, {6'd0, mode});
    write_reg(REG_DIVIDER, div);
    rx_idle_pct = idle_pct;
    if (long_hold) hold_req = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (mid_pause && n == count / 2) settle();
      send_cmd(random_cmd(tick_pct), idle_pct);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rx_idle_pct = 15;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_TICK;
    in_ch.left_level  = '0;
    in_ch.right_level = '0;
    in_ch.effect_on   = 1'b0;
    in_ch.mix_percent = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MODE;
    cfg_ch.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed commands at the reset settings: extreme levels, every mix
    // corner (no attenuation, last table entry, mute, above one hundred),
    // effect on and off, and the unused command codes.
    send_cmd(make_cmd(CMD_WET, 8'hFF, 8'hFF, 1'b0, 7'd0), 0);
    send_cmd(make_cmd(CMD_DRY, 8'h00, 8'hFF, 1'b1, 7'h7F), 0);
    send_cmd(make_cmd(CMD_ONOFF, 8'h00, 8'h00, 1'b1, 7'd0), 0);
    send_cmd(make_cmd(CMD_MIX, 8'h00, 8'h00, 1'b0, 7'd0), 0);
    send_cmd(make_cmd(CMD_MIX, 8'h00, 8'h00, 1'b0, 7'd99), 0);
    send_cmd(make_cmd(CMD_MIX, 8'h00, 8'h00, 1'b0, MIX_FULL), 0);
    send_cmd(make_cmd(CMD_MIX, 8'hFF, 8'hFF, 1'b1, 7'h7F), 0);
    send_cmd(make_cmd(CMD_WET, 8'h00, 8'h00, 1'b0, 7'd0), 0);
    send_cmd(make_cmd(CMD_WET, 8'h01, 8'hFE, 1'b0, 7'd0), 0);
    send_cmd(make_cmd(CMD_MIX, 8'h00, 8'h00, 1'b0, 7'd27), 0);
    send_cmd(make_cmd(CMD_ONOFF, 8'hFF, 8'hFF, 1'b0, 7'h7F), 0);
    send_cmd(make_cmd(CMD_UNUSED_LO, 8'hFF, 8'hFF, 1'b1, 7'h7F), 0);
    send_cmd(make_cmd(CMD_UNUSED_LO + 3'd1, 8'hAA, 8'h55, 1'b1, 7'h55), 0);
    send_cmd(make_cmd(CMD_UNUSED_LO + 3'd2, 8'h55, 8'hAA, 1'b0, 7'h2A), 0);
    send_cmd(make_cmd(CMD_DRY, 8'hFF, 8'h00, 1'b0, 7'd0), 0);

    // Enough ticks for the reset divider to fire.
    for (int n = 0; n < 210; n++)
      send_cmd(make_cmd(CMD_TICK, pick_level(), pick_level(), 1'($urandom_range(1)),
                        7'($urandom_range(127))), 15);

    run_phase(MODE_AUTO,   8'd1,   160, 70, 20, 1'b0, 1'b0);
    run_phase(MODE_EXCL,   8'd2,   200, 75, 15, 1'b1, 1'b0);
    run_phase(MODE_MANUAL, 8'd1,   170, 70, 25, 1'b0, 1'b0);
    run_phase(MODE_RSVD,   8'd3,   150, 75, 10, 1'b0, 1'b0);
    run_phase(MODE_AUTO,   8'd0,   170, 85, 15, 1'b0, 1'b1);
    run_phase(MODE_EXCL,   8'd255, 330, 95, 10, 1'b0, 1'b0);
    run_phase(MODE_MANUAL, 8'd4,   120, 80, 20, 1'b0, 1'b0);
    // Last stretch runs without idling on either side.
    run_phase(MODE_AUTO,   8'd1,   230, 80, 0,  1'b0, 1'b0);

    settle();
    if (fail_count == 0 && words_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
